// File: rtl/dpst_pkg.sv
// ----------------------------------------------------------------------------
// dpst_pkg: shared types and constants
// Field widths, register indexes and reset values of the dual pedal sensor
// torque request block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpst_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned TORQUE_W   = 16;
  localparam int unsigned LIMIT_W    = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned COUNT_MAX  = 1023;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_MIN   = 3'd0,
    CFG_LEFT_MAX   = 3'd1,
    CFG_RIGHT_MIN  = 3'd2,
    CFG_RIGHT_MAX  = 3'd3,
    CFG_TQ_FLOOR   = 3'd4,
    CFG_TQ_CEILING = 3'd5,
    CFG_MISMATCH   = 3'd6
  } cfg_reg_e;

endpackage

`default_nettype wire

// File: rtl/dual_pedal_sensor_torque_request.sv
// ----------------------------------------------------------------------------
// dual_pedal_sensor_torque_request: pedal plausibility check and torque map
// Two redundant pedal samples are clamped and scaled to percent, checked
// against each other, averaged and mapped onto the torque range.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, left/right_sample_i | sample pair in
//  out     | out_valid_o/out_ready_i, torque_command_o,  | result out
//          | implausible_o                             |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i,      | register write
//          | cfg_data_i                                |
//
// One item per cycle while in_ready_o is high. Stages: prep, percent divider,
// compare, multiply, reciprocal multiply, output register. Reset clears all
// valid bits and loads register defaults. The pipe advances as a whole; a
// two-entry output (register plus skid) lets it run on while a result waits,
// and in_ready_o drops only when both hold.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_pedal_sensor_torque_request #(
  parameter int unsigned PERCENT_SCALE = 100,
  parameter int unsigned SAMPLE_MAX    = 1023
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [dpst_pkg::SAMPLE_W-1:0]   left_sample_i,
  input  wire logic [dpst_pkg::SAMPLE_W-1:0]   right_sample_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [dpst_pkg::TORQUE_W-1:0]   torque_command_o,
  output logic                                 implausible_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dpst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dpst_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import dpst_pkg::*;

  localparam int unsigned PCT_W  = $clog2(PERCENT_SCALE + 1);
  localparam int unsigned SAT    = (SAMPLE_MAX < COUNT_MAX) ? SAMPLE_MAX : COUNT_MAX;
  localparam int unsigned PNUM_W = SAMPLE_W + PCT_W;
  localparam int unsigned TNUM_W = PCT_W + TORQUE_W;
  localparam int unsigned CMP_W  = (PCT_W > LIMIT_W) ? PCT_W : LIMIT_W;
  // valid bits: prep, percent divider, compare, multiply, reciprocal multiply
  localparam int unsigned NSTG   = PCT_W + 4;

  // divide by the percent scale as a reciprocal multiply, exact for any
  // dividend below 2**TNUM_W
  localparam int unsigned     RSH   = TNUM_W + $clog2(PERCENT_SCALE);
  localparam int unsigned     RCP_W = TNUM_W + 1;
  localparam int unsigned     RP_W  = TNUM_W + RCP_W;
  localparam longint unsigned RCP   = ((64'd1 << RSH) + 64'(PERCENT_SCALE) - 64'd1)
                                      / 64'(PERCENT_SCALE);

  // configuration registers
  logic [SAMPLE_W-1:0] left_min_q, left_max_q, right_min_q, right_max_q;
  logic [TORQUE_W-1:0] floor_q, ceiling_q;
  logic [LIMIT_W-1:0]  limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_min_q  <= '0;
      left_max_q  <= SAMPLE_W'(COUNT_MAX);
      right_min_q <= '0;
      right_max_q <= SAMPLE_W'(COUNT_MAX);
      floor_q     <= '0;
      ceiling_q   <= '1;
      limit_q     <= LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_LEFT_MIN:   left_min_q  <= cfg_data_i[SAMPLE_W-1:0];
        CFG_LEFT_MAX:   left_max_q  <= cfg_data_i[SAMPLE_W-1:0];
        CFG_RIGHT_MIN:  right_min_q <= cfg_data_i[SAMPLE_W-1:0];
        CFG_RIGHT_MAX:  right_max_q <= cfg_data_i[SAMPLE_W-1:0];
        CFG_TQ_FLOOR:   floor_q     <= cfg_data_i[TORQUE_W-1:0];
        CFG_TQ_CEILING: ceiling_q   <= cfg_data_i[TORQUE_W-1:0];
        CFG_MISMATCH:   limit_q     <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic            adv;
  logic [NSTG-1:0] v_q;
  logic            s_v_q;

  assign adv        = !s_v_q;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // stage 0: clamp, offset and scale; a degenerate window divides 0 by 1
  function automatic logic [PNUM_W+SAMPLE_W-1:0] prep(
    input logic [SAMPLE_W-1:0] s,
    input logic [SAMPLE_W-1:0] lo,
    input logic [SAMPLE_W-1:0] hi
  );
    logic [SAMPLE_W-1:0] c;
    logic [PNUM_W-1:0]   n;
    c = (s > SAMPLE_W'(SAT)) ? SAMPLE_W'(SAT) : s;
    if (hi <= lo) begin
      return {PNUM_W'(0), SAMPLE_W'(1)};
    end
    if (c > hi) c = hi;
    if (c < lo) c = lo;
    n = PNUM_W'(c - lo) * PNUM_W'(PERCENT_SCALE);
    return {n, SAMPLE_W'(hi - lo)};
  endfunction

  logic [PNUM_W-1:0]   lnum_q, rnum_q;
  logic [SAMPLE_W-1:0] lden_q, rden_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      {lnum_q, lden_q} <= prep(left_sample_i, left_min_q, left_max_q);
      {rnum_q, rden_q} <= prep(right_sample_i, right_min_q, right_max_q);
    end
  end

  logic [PCT_W-1:0] lpct, rpct;

  dpst_div #(.NUM_W(PNUM_W), .DEN_W(SAMPLE_W), .QUO_W(PCT_W)) u_div_left (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (lnum_q),
    .den_i (lden_q),
    .quo_o (lpct)
  );

  dpst_div #(.NUM_W(PNUM_W), .DEN_W(SAMPLE_W), .QUO_W(PCT_W)) u_div_right (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (rnum_q),
    .den_i (rden_q),
    .quo_o (rpct)
  );

  // compare and average
  logic [PCT_W-1:0] diff;
  logic [PCT_W:0]   pct_sum;
  logic             bad;
  logic [PCT_W-1:0] req_q;
  logic             bad_cmp_q;

  assign diff    = (lpct > rpct) ? (lpct - rpct) : (rpct - lpct);
  assign pct_sum = {1'b0, lpct} + {1'b0, rpct};
  assign bad     = CMP_W'(diff) > CMP_W'(limit_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      req_q     <= bad ? '0 : pct_sum[PCT_W:1];
      bad_cmp_q <= bad;
    end
  end

  // scale by the torque span
  logic [TORQUE_W-1:0] span;
  logic [TNUM_W-1:0]   prod_q;
  logic                bad_mul_q;

  assign span = (ceiling_q >= floor_q) ? (ceiling_q - floor_q) : '0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q    <= TNUM_W'(req_q) * TNUM_W'(span);
      bad_mul_q <= bad_cmp_q;
    end
  end

  logic [RP_W-1:0]     rprod;
  logic [TORQUE_W-1:0] tq_q;
  logic                bad_rcp_q;

  assign rprod = RP_W'(prod_q) * RP_W'(RCP);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tq_q      <= rprod[RSH +: TORQUE_W];
      bad_rcp_q <= bad_mul_q;
    end
  end

  logic [TORQUE_W:0]   tq_sum;
  logic [TORQUE_W-1:0] tq_res;

  assign tq_sum = {1'b0, floor_q} + {1'b0, tq_q};
  assign tq_res = tq_sum[TORQUE_W] ? '1 : tq_sum[TORQUE_W-1:0];

  // output register and skid entry
  logic                o_v_q, o_v_d, s_v_d;
  logic                o_load, s_load, o_from_s;
  logic [TORQUE_W-1:0] o_tq_q, s_tq_q;
  logic                o_bad_q, s_bad_q;
  logic                take, incoming;

  assign take     = o_v_q && out_ready_i;
  assign incoming = adv && v_q[NSTG-1];

  always_comb begin
    o_v_d    = o_v_q;
    s_v_d    = s_v_q;
    o_load   = 1'b0;
    s_load   = 1'b0;
    o_from_s = 1'b0;
    if (s_v_q) begin
      if (take) begin
        o_from_s = 1'b1;
        s_v_d    = 1'b0;
      end
    end else if (incoming) begin
      if (!o_v_q || take) begin
        o_load = 1'b1;
        o_v_d  = 1'b1;
      end else begin
        s_load = 1'b1;
        s_v_d  = 1'b1;
      end
    end else if (take) begin
      o_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
      s_v_q <= 1'b0;
    end else begin
      o_v_q <= o_v_d;
      s_v_q <= s_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_from_s) begin
      o_tq_q  <= s_tq_q;
      o_bad_q <= s_bad_q;
    end else if (o_load) begin
      o_tq_q  <= tq_res;
      o_bad_q <= bad_rcp_q;
    end
    if (s_load) begin
      s_tq_q  <= tq_res;
      s_bad_q <= bad_rcp_q;
    end
  end

  assign out_valid_o      = o_v_q;
  assign torque_command_o = o_tq_q;
  assign implausible_o    = o_bad_q;

endmodule

`default_nettype wire

// File: rtl/dpst_div.sv
// ----------------------------------------------------------------------------
// dpst_div: pipelined restoring divider
// One quotient bit per register stage, MSB first. The dividend must be below
// den * 2**QUO_W. All stages advance together on en_i.
// ----------------------------------------------------------------------------
`default_nettype none

module dpst_div #(
  parameter int unsigned NUM_W = 17,
  parameter int unsigned DEN_W = 10,
  parameter int unsigned QUO_W = 7
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [QUO_W-1:0] quo_o
);

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W-1];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int unsigned SH = QUO_W - 1 - k;

    logic [NUM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [NUM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = NUM_W'(den_in) << SH;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (rem_in - trial) : rem_in;
        quo_q[k] <= quo_in | (QUO_W'(ge) << SH);
      end
    end

    if (k < QUO_W - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/dpst_checker.sv
// ----------------------------------------------------------------------------
// dpst_checker: port-level checks for the torque request block
// Watches the output handshake, input backpressure and the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module dpst_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_ready_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic [dpst_pkg::TORQUE_W-1:0]   torque_command_o,
  input wire logic                            implausible_o,
  input wire logic                            cfg_valid_i,
  input wire logic                            cfg_ready_o
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(torque_command_o) && $stable(implausible_o))
    else $error("result changed while stalled");

  // input backpressure only comes from a result that was held last cycle
  a_bp_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without output stall");

  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind dual_pedal_sensor_torque_request dpst_checker u_dpst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .torque_command_o (torque_command_o),
  .implausible_o    (implausible_o),
  .cfg_valid_i      (cfg_valid_i),
  .cfg_ready_o      (cfg_ready_o)
);

`default_nettype wire
